// ----- rtl/core/assert_macros.svh -----
// assertion helper macros for the sliding window cover count core
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled while reset is low
`define SWM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define SWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SWM_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/swmcc_pkg.sv -----
// shared types and constants for the sliding window cover count core
// no dependencies
package swmcc_pkg;

    localparam int unsigned POINT_W       = 32;
    localparam int unsigned ROPE_W        = 31;
    localparam int unsigned COUNT_W       = 11;
    localparam int unsigned WINDOW_DEPTH_DEF = 1024;

    typedef struct packed {
        logic signed [POINT_W-1:0] point;
        logic                      last_point;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] covered_count;
        logic [COUNT_W-1:0] best_count;
        logic               order_error;
        logic               window_saturated;
        logic               set_done;
    } out_word_t;

endpackage

// ----- rtl/core/sliding_window_max_cover_count_core.sv -----
// sliding window max cover count: fifo window of points kept in one memory
// depends on swmcc_pkg and assert_macros.svh
`include "assert_macros.svh"

// channel   ports                       word          accepted when
// input     s_valid s_ready s_data      in_word_t     s_valid && s_ready
// result    m_valid m_ready m_data      out_word_t    m_valid && m_ready
// config    cfg_we cfg_wdata            rope length   cfg_we
//
// a word is accepted in the idle state, then held in the check state for
// each head compare and pop, since each pop needs a fresh read of the next
// head entry from the window memory.
// reset (aresetn low, synchronous) empties the window and sets the rope
// length to 1; the memory itself is never cleared.
// a result waits in the output register; while it is not taken the core
// still finishes its pops, then holds in its check cycle with no further
// state change and accepts nothing new.
module sliding_window_max_cover_count_core #(
    parameter int unsigned WINDOW_DEPTH = swmcc_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  swmcc_pkg::in_word_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output swmcc_pkg::out_word_t              m_data,
    input  logic                              cfg_we,
    input  logic [swmcc_pkg::ROPE_W-1:0]      cfg_wdata
);

    localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned PW    = swmcc_pkg::POINT_W;
    localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(WINDOW_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } state_t;

    // control state
    state_t                      state_reg, state_next;
    logic [swmcc_pkg::ROPE_W-1:0] rope_reg;
    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            best_reg, best_next;
    logic signed [PW-1:0]        prev_reg, prev_next;
    logic                        have_prev_reg, have_prev_next;
    logic                        sat_reg, sat_next;
    logic                        m_valid_reg, m_valid_next;

    // payload holding registers
    logic signed [PW-1:0]        pt_reg;
    logic                        last_reg;
    swmcc_pkg::out_word_t        m_data_reg, m_data_next;

    // window memory, one write and one read port, registered read
    logic [PW-1:0]               window_mem [WINDOW_DEPTH];
    logic [PW-1:0]               rd_data_reg;
    logic [PTR_W-1:0]            rd_addr;
    logic                        mem_we;

    // datapath signals
    logic                        in_fire;
    logic                        out_free;
    logic                        order_err;
    logic                        rope_zero;
    logic signed [PW:0]          span_diff;
    logic                        pop_head;
    logic                        commit;
    logic                        push_en;
    logic                        win_full;
    logic [CNT_W-1:0]            cnt_after;
    logic [CNT_W-1:0]            best_after;
    logic [31:0]                 cov_ext;
    logic [31:0]                 best_ext;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // ordering check against the previous accepted point, span check against
    // the head entry that the memory keeps presented in rd_data_reg
    assign order_err = have_prev_reg && (pt_reg < prev_reg);
    assign rope_zero = (rope_reg == '0);
    assign span_diff = {pt_reg[PW-1], pt_reg} - $signed({rd_data_reg[PW-1], rd_data_reg});
    assign pop_head  = !order_err && !rope_zero && (count_reg != '0)
                       && (span_diff > $signed({2'b00, rope_reg}));

    // final check cycle: nothing left to pop and the output register is free
    assign commit   = (state_reg == ST_CHECK) && !pop_head && out_free;
    assign push_en  = commit && !order_err && !rope_zero;
    assign win_full = (count_reg == COUNT_FULL);

    // drop-oldest on a full window keeps the count at depth
    assign cnt_after  = win_full ? count_reg : count_reg + 1'b1;
    assign best_after = (cnt_after > best_reg) ? cnt_after : best_reg;

    assign mem_we  = push_en;
    assign rd_addr = head_next;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        best_next      = best_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        sat_next       = sat_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        cov_ext        = '0;
        best_ext       = 32'(best_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (pop_head) begin
                    // oldest point out of span, retire it and read the next
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end else if (commit) begin
                    if (!order_err) begin
                        prev_next      = pt_reg;
                        have_prev_next = 1'b1;
                    end
                    if (push_en) begin
                        tail_next  = ptr_inc(tail_reg);
                        count_next = cnt_after;
                        best_next  = best_after;
                        cov_ext    = 32'(cnt_after);
                        best_ext   = 32'(best_after);
                        if (win_full) begin
                            head_next = ptr_inc(head_reg);
                            sat_next  = 1'b1;
                        end
                    end
                    m_valid_next                 = 1'b1;
                    m_data_next.covered_count    = cov_ext[swmcc_pkg::COUNT_W-1:0];
                    m_data_next.best_count       = best_ext[swmcc_pkg::COUNT_W-1:0];
                    m_data_next.order_error      = order_err;
                    m_data_next.window_saturated = sat_next;
                    m_data_next.set_done         = last_reg;
                    // end of set: window pointers, counts and order state clear; the rope length stays
                    if (last_reg) begin
                        head_next      = '0;
                        tail_next      = '0;
                        count_next     = '0;
                        best_next      = '0;
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                        sat_next       = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rope_reg      <= swmcc_pkg::ROPE_W'(1);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            best_reg      <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            sat_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            best_reg      <= best_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            sat_reg       <= sat_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                rope_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pt_reg   <= s_data.point;
            last_reg <= s_data.last_point;
        end
        m_data_reg <= m_data_next;
    end

    // window memory; read address follows the next head pointer, and a
    // same-address write is forwarded so rd_data_reg always shows the head
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            window_mem[tail_reg] <= pt_reg;
        end
        if (mem_we && (tail_reg == rd_addr)) begin
            rd_data_reg <= pt_reg;
        end else begin
            rd_data_reg <= window_mem[rd_addr];
        end
    end

    `SWM_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= COUNT_FULL)
    `SWM_ASSERT_NOW(a_empty_ptrs, aclk, aresetn, count_reg == '0, head_reg == tail_reg)
    `SWM_ASSERT_NOW(a_full_ptrs, aclk, aresetn, count_reg == COUNT_FULL, head_reg == tail_reg)
    `SWM_ASSERT_NOW(a_best_covers, aclk, aresetn, 1'b1, best_reg >= count_reg)
    `SWM_ASSERT_NEXT(a_err_zero, aclk, aresetn, commit && order_err,
                     m_valid && (m_data.covered_count == '0))

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for sliding_window_max_cover_count_core
// holds a cover count scoreboard class and the top module tb_top
// depends on swmcc_pkg and the core rtl

class cover_count_board;
    localparam int unsigned DEPTH = swmcc_pkg::WINDOW_DEPTH_DEF;

    logic signed [swmcc_pkg::POINT_W-1:0] window_mem [DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned fill;
    int unsigned best;
    logic signed [swmcc_pkg::POINT_W-1:0] last_seen;
    bit seen_any;
    bit overflowed;
    logic [swmcc_pkg::ROPE_W-1:0] rope;
    swmcc_pkg::out_word_t due_counts[$];
    int errors;

    function new();
        rope   = swmcc_pkg::ROPE_W'(1);
        errors = 0;
        clear_set();
    endfunction

    function void clear_set();
        head       = 0;
        tail       = 0;
        fill       = 0;
        best       = 0;
        last_seen  = '0;
        seen_any   = 1'b0;
        overflowed = 1'b0;
    endfunction

    function void set_rope(logic [swmcc_pkg::ROPE_W-1:0] v);
        rope = v;
    endfunction

    function int pending();
        return due_counts.size();
    endfunction

    // expected result for one accepted input word
    function void note_point(swmcc_pkg::in_word_t w);
        swmcc_pkg::out_word_t r;
        logic signed [swmcc_pkg::POINT_W-1:0] p;
        p = w.point;
        r = '0;
        if (seen_any && p < last_seen) begin
            r.order_error = 1'b1;
        end else begin
            last_seen = p;
            seen_any  = 1'b1;
            if (rope != 0) begin
                // drop entries farther than the rope, 64-bit span
                while (fill > 0 &&
                       longint'(p) - longint'(window_mem[head]) > longint'(rope)) begin
                    head = (head + 1) % DEPTH;
                    fill--;
                end
                if (fill >= DEPTH) begin
                    head = (head + 1) % DEPTH;
                    fill--;
                    overflowed = 1'b1;
                end
                window_mem[tail] = p;
                tail = (tail + 1) % DEPTH;
                fill++;
                r.covered_count = fill[swmcc_pkg::COUNT_W-1:0];
                if (fill > best)
                    best = fill;
            end
        end
        r.best_count       = best[swmcc_pkg::COUNT_W-1:0];
        r.window_saturated = overflowed;
        r.set_done         = w.last_point;
        due_counts.push_back(r);
        if (w.last_point)
            clear_set();
    endfunction

    task report(string what, longint got, longint want);
        errors++;
        $display("tb_top: mismatch on %s: got %0d, want %0d", what, got, want);
    endtask

    task check_result(swmcc_pkg::out_word_t got);
        swmcc_pkg::out_word_t want;
        if (due_counts.size() == 0) begin
            report("result word with none pending", got, 0);
            return;
        end
        want = due_counts.pop_front();
        if (got.covered_count !== want.covered_count)
            report("covered_count", got.covered_count, want.covered_count);
        if (got.best_count !== want.best_count)
            report("best_count", got.best_count, want.best_count);
        if (got.order_error !== want.order_error)
            report("order_error", got.order_error, want.order_error);
        if (got.window_saturated !== want.window_saturated)
            report("window_saturated", got.window_saturated, want.window_saturated);
        if (got.set_done !== want.set_done)
            report("set_done", got.set_done, want.set_done);
    endtask
endclass

module tb_top;

    localparam logic [swmcc_pkg::ROPE_W-1:0]         ROPE_MAX  = 31'h7FFF_FFFF;
    localparam logic signed [swmcc_pkg::POINT_W-1:0] POINT_MIN = 32'h8000_0000;
    localparam logic signed [swmcc_pkg::POINT_W-1:0] POINT_MAX = 32'h7FFF_FFFF;
    localparam int unsigned                          TOTAL_WORDS = 450;

    // receiver stall styles
    typedef enum int unsigned {
        RX_ALWAYS,
        RX_TOGGLE,
        RX_COIN,
        RX_LONG_STALL
    } rx_mode_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    swmcc_pkg::in_word_t          s_data    = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    swmcc_pkg::out_word_t         m_data;
    logic                         cfg_we    = 1'b0;
    logic [swmcc_pkg::ROPE_W-1:0] cfg_wdata = '0;

    cover_count_board board = new();

    // sender burst state and tb copy of the rope
    int unsigned                  burst_left = 4;
    int unsigned                  words_sent = 0;
    logic [swmcc_pkg::ROPE_W-1:0] cur_rope   = swmcc_pkg::ROPE_W'(1);

    // receiver pattern state
    rx_mode_t    rx_mode = RX_ALWAYS;
    int unsigned rx_left = 0;
    int unsigned rx_hold = 0;

    sliding_window_max_cover_count_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watch both channels at the rising edge, before any flop updates land
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_point(s_data);
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
    end

    // receiver: switches between stall styles every so often
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(60, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_TOGGLE: m_ready <= !m_ready;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) != 0);
            default: begin
                // long low stretches with short high windows
                if (rx_hold == 0) begin
                    m_ready <= !m_ready;
                    rx_hold = m_ready ? $urandom_range(1, 24) : $urandom_range(1, 4);
                end else begin
                    rx_hold--;
                end
            end
        endcase
    end

    // present one word, entered and left at a falling edge; valid stays up
    // when the burst goes on, so the caller must send again or quiesce
    task automatic send_point(input logic signed [swmcc_pkg::POINT_W-1:0] p,
                              input logic last);
        swmcc_pkg::in_word_t w;
        w.point      = p;
        w.last_point = last;
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        words_sent++;
        @(negedge aclk);
        if (burst_left == 0) begin
            // gap before the next burst so valid never drops and rises in one step
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 10);
        end else begin
            burst_left--;
        end
    endtask

    // drop valid and wait for every pending result word
    task automatic quiesce();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge aclk);
    endtask

    // rope writes only happen with the core idle
    task automatic set_rope(input logic [swmcc_pkg::ROPE_W-1:0] v);
        quiesce();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        board.set_rope(v);
        cur_rope = v;
    endtask

    initial begin
        logic signed [swmcc_pkg::POINT_W-1:0] p;
        logic signed [swmcc_pkg::POINT_W-1:0] gen_prev;
        logic                                 gen_have;
        logic                                 last;
        longint                               nxt;
        int unsigned                          scale;
        int unsigned                          sel;
        int unsigned                          phase_len;

        gen_prev = '0;
        gen_have = 1'b0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset rope of 1, duplicates, multi-pop, out-of-order word
        send_point(-5, 1'b0);
        send_point(-5, 1'b0);
        send_point(-4, 1'b0);
        send_point(-3, 1'b0);
        send_point(-4, 1'b0);
        send_point(10, 1'b1);

        // widest rope against the full point range, out-of-order last word
        set_rope(ROPE_MAX);
        send_point(POINT_MIN, 1'b0);
        send_point(0, 1'b0);
        send_point(POINT_MAX, 1'b0);
        send_point(POINT_MAX, 1'b0);
        send_point(5, 1'b1);

        // zero rope: counts stay zero, order check still live
        set_rope('0);
        send_point(1, 1'b0);
        send_point(2, 1'b0);
        send_point(2, 1'b0);
        send_point(1, 1'b0);
        send_point(7, 1'b1);

        // rope change in the middle of a set
        set_rope(swmcc_pkg::ROPE_W'(2));
        send_point(0, 1'b0);
        send_point(1, 1'b0);
        send_point(2, 1'b0);
        set_rope(swmcc_pkg::ROPE_W'(1));
        send_point(3, 1'b1);

        // random phases, each with its own rope setting
        while (words_sent < TOTAL_WORDS) begin
            case ($urandom_range(0, 5))
                0:       set_rope('0);
                1:       set_rope(swmcc_pkg::ROPE_W'(1));
                2:       set_rope(ROPE_MAX);
                3:       set_rope(swmcc_pkg::ROPE_W'($urandom_range(2, 8)));
                4:       set_rope(swmcc_pkg::ROPE_W'($urandom_range(9, 500)));
                default: set_rope(swmcc_pkg::ROPE_W'($urandom()) & ROPE_MAX);
            endcase
            if (cur_rope == 0)
                scale = 4;
            else if (cur_rope > 100000)
                scale = 100000;
            else
                scale = 32'(cur_rope);
            phase_len = $urandom_range(25, 70);
            for (int k = 0; k < phase_len; k++) begin
                sel = $urandom_range(0, 99);
                if (!gen_have) begin
                    // new set starts anywhere or near zero
                    if ($urandom_range(0, 1) != 0)
                        p = $urandom();
                    else
                        p = $urandom_range(0, 400) - 200;
                end else if (sel < 4) begin
                    p = $urandom();
                end else if (sel < 12) begin
                    // step backwards, flagged and ignored
                    nxt = longint'(gen_prev) - longint'($urandom_range(1, 64));
                    if (nxt < longint'(POINT_MIN))
                        nxt = longint'(POINT_MIN);
                    p = nxt[swmcc_pkg::POINT_W-1:0];
                end else begin
                    // well-formed step sized against the rope
                    case ($urandom_range(0, 3))
                        0:       nxt = longint'(gen_prev);
                        1:       nxt = longint'(gen_prev) + $urandom_range(1, 3);
                        2:       nxt = longint'(gen_prev) + $urandom_range(0, scale);
                        default: nxt = longint'(gen_prev) + $urandom_range(scale, 3 * scale);
                    endcase
                    if (nxt > longint'(POINT_MAX))
                        nxt = longint'(POINT_MAX);
                    p = nxt[swmcc_pkg::POINT_W-1:0];
                end
                if (!gen_have || p >= gen_prev) begin
                    gen_prev = p;
                    gen_have = 1'b1;
                end
                last = ($urandom_range(0, 24) == 0);
                if (last)
                    gen_have = 1'b0;
                send_point(p, last);
                // now and then hold off until the core has drained
                if ($urandom_range(0, 79) == 0)
                    quiesce();
            end
        end

        quiesce();
        repeat (16) @(negedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- sliding_window_max_cover_count_core.f -----
+incdir+rtl/core
rtl/core/swmcc_pkg.sv
rtl/core/sliding_window_max_cover_count_core.sv
tb/tb_top.sv
